/* rtl/core/hte_pkg.sv */
package hte_pkg;

    localparam int DATA_W            = 32;
    localparam int DIM_DEFAULT       = 4;
    localparam int FRAC_BITS_DEFAULT = 16;

    // command codes on the input channel
    typedef enum logic [1:0] {
        CMD_WR_CUR = 2'd0,
        CMD_WR_STG = 2'd1,
        CMD_CONCAT = 2'd2,
        CMD_XFORM  = 2'd3
    } cmd_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_RUN  = 1'b1
    } state_t;

endpackage

/* rtl/core/homogeneous_transform_engine_core.sv */
// Homogeneous transform engine: DIM x DIM signed Q16.16 matrix engine.
// Command channel (cmd_valid / cmd_stall) carries one item per command:
//   write current element, write staging element, concatenate
//   (current = current * staging) and transform vertex. Only a transform
//   produces an item on the result channel (res_valid / res_stall).
// Element writes take effect at the accept; the next item can follow at once.
// Transform: the result loads the output register once the accumulate
//   stage is done and the register is free.
//   One column of the current matrix is read per cycle from its memory
//   port and fed to DIM multiply-accumulate lanes (read, multiply,
//   accumulate stages).
// Concatenate: one column-by-element step per cycle through the same lanes;
//   the product lands in the other half of the current-matrix memory,
//   which then becomes current.
// Reset: the current matrix reads as identity and the staging matrix as
//   zero; per-element valid flops supply those values until written, so
//   no clearing pass is needed and items are taken right after reset.
// Receiver stall: a finished result waits in the output register; a
//   following transform runs up to its final step and holds there until
//   the register frees. cmd_stall is high while a matrix command runs.
module homogeneous_transform_engine_core #(
    parameter int DIM       = hte_pkg::DIM_DEFAULT,
    parameter int FRAC_BITS = hte_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cmd_valid,
    output logic                              cmd_stall,
    input  logic [1:0]                        command,
    input  logic [3:0]                        element_index,
    input  logic signed [hte_pkg::DATA_W-1:0] element_value,
    input  logic signed [hte_pkg::DATA_W-1:0] vec_x,
    input  logic signed [hte_pkg::DATA_W-1:0] vec_y,
    input  logic signed [hte_pkg::DATA_W-1:0] vec_z,
    input  logic signed [hte_pkg::DATA_W-1:0] vec_w,

    output logic                              res_valid,
    input  logic                              res_stall,
    output logic signed [hte_pkg::DATA_W-1:0] out_x,
    output logic signed [hte_pkg::DATA_W-1:0] out_y,
    output logic signed [hte_pkg::DATA_W-1:0] out_z,
    output logic signed [hte_pkg::DATA_W-1:0] out_w
);

    localparam int DW        = hte_pkg::DATA_W;
    localparam int COL_W     = $clog2(DIM);
    localparam int CUR_DEPTH = 2 * DIM;           // two banks of DIM columns
    localparam int CUR_AW    = $clog2(CUR_DEPTH);
    localparam int NELEM     = DIM * DIM;
    localparam int PROD_W    = 2 * DW;
    localparam int ACC_W     = PROD_W + $clog2(DIM);
    localparam logic [DW-1:0] ONE_Q = DW'(1) << FRAC_BITS;

    typedef logic [DIM-1:0][DW-1:0] col_t;

    // ------------------------------------------------------------------
    // Saturate (acc >>> FRAC_BITS) into the signed 32-bit range
    // ------------------------------------------------------------------
    function automatic logic [DW-1:0] sat_q(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] sh;
        logic [ACC_W-DW:0]       upper;
        logic [DW-1:0]           res;
        sh    = v >>> FRAC_BITS;
        upper = sh[ACC_W-1:DW-1];
        if ((&upper) || (~|upper))
            res = sh[DW-1:0];
        else if (sh[ACC_W-1])
            res = {1'b1, {(DW-1){1'b0}}};
        else
            res = {1'b0, {(DW-1){1'b1}}};
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    hte_pkg::state_t state_reg, state_next;
    logic            bank_reg;       // which half of cur_mem is current
    logic            is_cat_reg;     // running command is a concatenate

    logic             iss_busy_reg;
    logic [COL_W-1:0] iss_k_reg;
    logic [COL_W-1:0] iss_c_reg;

    logic             s1_vld_reg, s1_first_reg, s1_last_reg;
    logic [COL_W-1:0] s1_k_reg, s1_c_reg;
    logic             s2_vld_reg, s2_first_reg, s2_last_reg;
    logic [COL_W-1:0] s2_c_reg;
    logic             fin_reg, fin_next;
    logic [COL_W-1:0] fin_c_reg;

    logic             res_valid_reg, res_valid_next;
    logic [DW-1:0]    out_x_reg, out_y_reg, out_z_reg, out_w_reg;

    // ------------------------------------------------------------------
    // Memories and their valid flops
    // ------------------------------------------------------------------
    col_t cur_mem [CUR_DEPTH];
    col_t stg_mem [DIM];
    logic [CUR_DEPTH-1:0][DIM-1:0] cur_vld_reg;
    logic [DIM-1:0][DIM-1:0]       stg_vld_reg;

    col_t           cur_rd_reg, stg_rd_reg;
    logic [DIM-1:0] cur_rd_vld_reg, stg_rd_vld_reg;

    logic signed [DW-1:0] vec_reg [DIM];
    logic signed [DW-1:0] vec_in  [4];

    // ------------------------------------------------------------------
    // Command decode
    // ------------------------------------------------------------------
    hte_pkg::cmd_t cmd;
    logic          cmd_accept, start_run;
    logic          el_in_range;
    logic [COL_W-1:0] el_col, el_row;
    logic [3:0]       el_base;

    assign cmd        = hte_pkg::cmd_t'(command);
    assign cmd_accept = cmd_valid && !cmd_stall;
    assign el_in_range = {1'b0, element_index} < 5'(NELEM);

    // element = row + DIM * column
    always_comb
    begin
        el_col  = '0;
        el_base = '0;
        for (int c = 1; c < DIM; c++)
        begin
            if ({1'b0, element_index} >= 5'(c * DIM))
            begin
                el_col  = COL_W'(c);
                el_base = 4'(c * DIM);
            end
        end
        el_row = COL_W'(element_index - el_base);
    end

    assign vec_in[0] = vec_x;
    assign vec_in[1] = vec_y;
    assign vec_in[2] = vec_z;
    assign vec_in[3] = vec_w;

    // ------------------------------------------------------------------
    // State machine
    // ------------------------------------------------------------------
    logic fin_done, res_free, fin_last;

    assign res_free = !res_valid_reg || !res_stall;
    assign fin_done = is_cat_reg || res_free;
    assign fin_last = !is_cat_reg || (fin_c_reg == COL_W'(DIM - 1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hte_pkg::ST_IDLE:
            begin
                if (cmd_accept && (cmd == hte_pkg::CMD_CONCAT || cmd == hte_pkg::CMD_XFORM))
                    state_next = hte_pkg::ST_RUN;
            end
            hte_pkg::ST_RUN:
            begin
                if (fin_reg && fin_done && fin_last)
                    state_next = hte_pkg::ST_IDLE;
            end
            default:
                state_next = hte_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_stall = 1'b1;
        start_run = 1'b0;
        case (state_reg)
            hte_pkg::ST_IDLE:
            begin
                cmd_stall = 1'b0;
                start_run = cmd_valid &&
                            (cmd == hte_pkg::CMD_CONCAT || cmd == hte_pkg::CMD_XFORM);
            end
            hte_pkg::ST_RUN:
                cmd_stall = 1'b1;
            default:
                cmd_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= hte_pkg::ST_IDLE;
            is_cat_reg <= 1'b0;
            bank_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_run)
                is_cat_reg <= (cmd == hte_pkg::CMD_CONCAT);
            // product is complete: the other bank becomes current
            if (fin_reg && is_cat_reg && fin_last)
                bank_reg <= !bank_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_run)
        begin
            for (int r = 0; r < DIM; r++)
                vec_reg[r] <= vec_in[r];
        end
    end

    // ------------------------------------------------------------------
    // Read issue: one current column per cycle (k), staging column c
    // ------------------------------------------------------------------
    logic [CUR_AW-1:0] rd_addr;
    assign rd_addr = bank_reg ? CUR_AW'(DIM) + CUR_AW'(iss_k_reg) : CUR_AW'(iss_k_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_busy_reg <= 1'b0;
            iss_k_reg    <= '0;
            iss_c_reg    <= '0;
        end
        else if (start_run)
        begin
            iss_busy_reg <= 1'b1;
            iss_k_reg    <= '0;
            iss_c_reg    <= '0;
        end
        else if (iss_busy_reg)
        begin
            if (iss_k_reg == COL_W'(DIM - 1))
            begin
                iss_k_reg <= '0;
                if (!is_cat_reg || iss_c_reg == COL_W'(DIM - 1))
                    iss_busy_reg <= 1'b0;
                else
                    iss_c_reg <= iss_c_reg + COL_W'(1);
            end
            else
            begin
                iss_k_reg <= iss_k_reg + COL_W'(1);
            end
        end
    end

    // pipeline flags: read -> multiply -> accumulate -> finish
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_k_reg     <= '0;
            s1_c_reg     <= '0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_last_reg  <= 1'b0;
            s2_c_reg     <= '0;
            fin_reg      <= 1'b0;
            fin_c_reg    <= '0;
        end
        else
        begin
            s1_vld_reg   <= iss_busy_reg;
            s1_first_reg <= (iss_k_reg == '0);
            s1_last_reg  <= (iss_k_reg == COL_W'(DIM - 1));
            s1_k_reg     <= iss_k_reg;
            s1_c_reg     <= iss_c_reg;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_last_reg  <= s1_last_reg;
            s2_c_reg     <= s1_c_reg;
            fin_reg      <= fin_next;
            if (s2_vld_reg && s2_last_reg)
                fin_c_reg <= s2_c_reg;
        end
    end

    // a transform result holds in the accumulators until it can be posted
    assign fin_next = (s2_vld_reg && s2_last_reg) || (fin_reg && !fin_done);

    // ------------------------------------------------------------------
    // Multiply and accumulate lanes, one per matrix row
    // ------------------------------------------------------------------
    logic signed [DW-1:0]     a_op [DIM];
    logic signed [DW-1:0]     b_op;
    logic signed [PROD_W-1:0] prod_reg [DIM];
    logic signed [ACC_W-1:0]  acc_reg  [DIM];
    logic [DW-1:0]            sat_res  [DIM];

    always_comb
    begin
        for (int r = 0; r < DIM; r++)
            sat_res[r] = sat_q(acc_reg[r]);
    end

    always_comb
    begin
        // unwritten current elements read as identity, staging as zero
        for (int r = 0; r < DIM; r++)
        begin
            if (cur_rd_vld_reg[r])
                a_op[r] = cur_rd_reg[r];
            else if (COL_W'(r) == s1_k_reg)
                a_op[r] = ONE_Q;
            else
                a_op[r] = '0;
        end
        if (!is_cat_reg)
            b_op = vec_reg[s1_k_reg];
        else if (stg_rd_vld_reg[s1_k_reg])
            b_op = stg_rd_reg[s1_k_reg];
        else
            b_op = '0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            for (int r = 0; r < DIM; r++)
                prod_reg[r] <= a_op[r] * b_op;
        end
        if (s2_vld_reg)
        begin
            for (int r = 0; r < DIM; r++)
                acc_reg[r] <= (s2_first_reg ? {ACC_W{1'b0}} : acc_reg[r]) +
                              {{(ACC_W-PROD_W){prod_reg[r][PROD_W-1]}}, prod_reg[r]};
        end
    end

    // ------------------------------------------------------------------
    // Memory write port (element write or finished product column)
    // ------------------------------------------------------------------
    logic              cur_we, stg_we;
    logic [CUR_AW-1:0] cur_wa;
    logic [COL_W-1:0]  stg_wa;
    logic [DIM-1:0]    cur_wmask, stg_wmask;
    col_t              cur_wd, stg_wd;

    always_comb
    begin
        cur_we    = 1'b0;
        cur_wa    = bank_reg ? CUR_AW'(DIM) + CUR_AW'(el_col) : CUR_AW'(el_col);
        cur_wmask = DIM'(1) << el_row;
        for (int r = 0; r < DIM; r++)
            cur_wd[r] = element_value;
        stg_we    = cmd_accept && cmd == hte_pkg::CMD_WR_STG && el_in_range;
        stg_wa    = el_col;
        stg_wmask = DIM'(1) << el_row;
        for (int r = 0; r < DIM; r++)
            stg_wd[r] = element_value;

        if (cmd_accept && cmd == hte_pkg::CMD_WR_CUR && el_in_range)
        begin
            cur_we = 1'b1;
        end
        else if (fin_reg && is_cat_reg)
        begin
            cur_we    = 1'b1;
            cur_wa    = bank_reg ? CUR_AW'(fin_c_reg) : CUR_AW'(DIM) + CUR_AW'(fin_c_reg);
            cur_wmask = '1;
            for (int r = 0; r < DIM; r++)
                cur_wd[r] = sat_res[r];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cur_we)
        begin
            for (int r = 0; r < DIM; r++)
                if (cur_wmask[r])
                    cur_mem[cur_wa][r] <= cur_wd[r];
        end
        if (stg_we)
        begin
            for (int r = 0; r < DIM; r++)
                if (stg_wmask[r])
                    stg_mem[stg_wa][r] <= stg_wd[r];
        end
        if (iss_busy_reg)
        begin
            cur_rd_reg     <= cur_mem[rd_addr];
            stg_rd_reg     <= stg_mem[iss_c_reg];
            cur_rd_vld_reg <= cur_vld_reg[rd_addr];
            stg_rd_vld_reg <= stg_vld_reg[iss_c_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_vld_reg <= '0;
            stg_vld_reg <= '0;
        end
        else
        begin
            if (cur_we)
                cur_vld_reg[cur_wa] <= cur_vld_reg[cur_wa] | cur_wmask;
            if (stg_we)
                stg_vld_reg[stg_wa] <= stg_vld_reg[stg_wa] | stg_wmask;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic          res_load;
    logic [DW-1:0] res_lane [4];

    for (genvar r = 0; r < 4; r++)
    begin : g_lane
        if (r < DIM)
        begin : g_used
            assign res_lane[r] = sat_res[r];
        end
        else
        begin : g_zero
            assign res_lane[r] = '0;
        end
    end

    assign res_load       = fin_reg && !is_cat_reg && res_free;
    assign res_valid_next = res_load || (res_valid_reg && res_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else
            res_valid_reg <= res_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            out_x_reg <= res_lane[0];
            out_y_reg <= res_lane[1];
            out_z_reg <= res_lane[2];
            out_w_reg <= res_lane[3];
        end
    end

    assign res_valid = res_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_w     = out_w_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_res_from_xform: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(fin_reg && !is_cat_reg))
        else $error("result posted without a finished transform");

    a_bank_flip: assert property (@(posedge clk) disable iff (!rst_n)
        (bank_reg != $past(bank_reg)) |-> $past(state_reg == hte_pkg::ST_RUN && is_cat_reg))
        else $error("bank switched outside a concatenate");

    a_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_reg && !fin_done) |-> (!s2_vld_reg && !iss_busy_reg))
        else $error("result hold while lanes still busy");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_we && iss_busy_reg) |-> (cur_wa != rd_addr))
        else $error("write hits the column being read");

endmodule
